// ===== rtl/core/tlpt_pkg.sv =====
package tlpt_pkg;

    localparam int FRAME_W = 20;
    localparam int ATTR_W  = 12;
    localparam int IDX_W   = 10;
    localparam int ENTRY_W = 32;
    localparam int CFG_W   = 2;

    localparam logic [CFG_W-1:0] CFG_ALLOC_START = 2'd0;
    localparam logic [CFG_W-1:0] CFG_ALLOC_LIMIT = 2'd1;
    localparam logic [CFG_W-1:0] CFG_POOL_BASE   = 2'd2;

    localparam logic [FRAME_W-1:0] RST_ALLOC_START = 20'd256;
    localparam logic [FRAME_W-1:0] RST_ALLOC_LIMIT = 20'd1023;
    localparam logic [FRAME_W-1:0] RST_POOL_BASE   = 20'd256;

    typedef enum logic {
        OP_MAP   = 1'b0,
        OP_UNMAP = 1'b1
    } t_opcode;

    typedef enum logic [1:0] {
        ST_DONE       = 2'd0,
        ST_NOT_MAPPED = 2'd1,
        ST_NO_TABLE   = 2'd2,
        ST_OUT_POOL   = 2'd3
    } t_status;

    typedef enum logic [2:0] {
        S_SWEEP,
        S_IDLE,
        S_CHK,
        S_PDE,
        S_TCLR,
        S_WR_PDE,
        S_WR_PTE,
        S_PTE
    } t_state;

endpackage

// ===== rtl/core/tlpt_ram.sv =====
module tlpt_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        r_rdata <= r_mem[i_addr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/core/two_level_page_table_map_unmap_core.sv =====
// Two-level page-table map/unmap engine.
// Requests arrive on the s-side stream: tuser carries the opcode (map or unmap),
// tdata carries directory frame, virtual page, physical frame and attributes.
// Each request yields exactly one result word on the m-side stream: tuser holds
// the status code and the flush flag, tdata holds the removed frame of an unmap.
// The table pool lives in one single-port RAM of POOL_FRAMES*1024 words.
// A request is worked off in steps: one RAM read of the directory entry, then
// either a direct table-entry write (map) or a second read and a clearing write
// (unmap). A map that allocates a new table first clears that table with one RAM
// write per table entry, then writes the directory entry, then the table entry.
// The single RAM port bounds the rate; one request is in work at a time, and the
// next one can be taken from the cycle after the result moves on.
// After reset the block sweeps the whole RAM to zero, one word per cycle, and
// accepts no request meanwhile; configuration writes are taken at any time. A
// finished result waits in the output register while the receiver stalls; the
// next request may already be accepted, and the engine holds its result until
// the output register frees.
module two_level_page_table_map_unmap_core #(
    parameter int POOL_FRAMES = 64
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // s-side: tdata = dir_frame, virt_page, phys_frame, attr_bits (low to high)
    input  logic                           i_s_tvalid,
    output logic                           o_s_tready,
    input  logic [71:0]                    i_s_tdata,
    // tuser = opcode
    input  logic                           i_s_tuser,
    // m-side: tdata = old_frame (zero padded)
    output logic                           o_m_tvalid,
    input  logic                           i_m_tready,
    output logic [23:0]                    o_m_tdata,
    // tuser = status, tlb_flush (low to high)
    output logic [2:0]                     o_m_tuser,
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [tlpt_pkg::CFG_W-1:0]     i_cfg_index,
    input  logic [tlpt_pkg::FRAME_W-1:0]   i_cfg_data
);

    import tlpt_pkg::*;

    localparam int PW    = $clog2(POOL_FRAMES);
    localparam int DEPTH = POOL_FRAMES * (2 ** IDX_W);
    localparam int AW    = PW + IDX_W;
    localparam logic [AW-1:0]      LAST_ADDR = AW'(DEPTH - 1);
    localparam logic [FRAME_W-1:0] POOL_N    = FRAME_W'(POOL_FRAMES);

    t_state              r_state, n_state;
    logic [AW-1:0]       r_clr, n_clr;
    t_opcode             r_op;
    logic [FRAME_W-1:0]  r_dir, r_vp, r_phys;
    logic [ATTR_W-1:0]   r_attrs;
    logic [FRAME_W-1:0]  r_table, n_table;
    logic [PW-1:0]       r_toff, n_toff;
    t_status             r_status, n_status;
    logic [FRAME_W-1:0]  r_old, n_old;
    logic                r_flush, n_flush;
    logic                r_done, n_done;
    logic [FRAME_W-1:0]  r_limit, r_base;
    logic [FRAME_W-1:0]  r_next, n_next;
    logic                r_m_valid;
    t_status             r_m_status;
    logic [FRAME_W-1:0]  r_m_old;
    logic                r_m_flush;

    logic                ram_we;
    logic [AW-1:0]       ram_addr;
    logic [ENTRY_W-1:0]  ram_wdata, ram_rdata;

    logic [FRAME_W-1:0]  off_dir, cand, off_cand;
    logic                dir_in, cand_in, pde_present;
    logic [AW-1:0]       pde_addr, pte_addr;
    logic                s_accept, cfg_wr, out_free;

    tlpt_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_addr  (ram_addr),
        .i_wdata (ram_wdata),
        .o_rdata (ram_rdata)
    );

    assign o_s_tready = (r_state == S_IDLE) && !r_done;
    assign s_accept   = i_s_tvalid && o_s_tready;
    assign o_cfg_ready = 1'b1;
    assign cfg_wr     = i_cfg_valid;
    assign out_free   = !r_m_valid || i_m_tready;

    assign off_dir     = r_dir - r_base;
    assign dir_in      = (r_dir >= r_base) && (off_dir < POOL_N);
    assign pde_present = ram_rdata[0];
    assign cand        = pde_present ? ram_rdata[ENTRY_W-1:ATTR_W] : r_next;
    assign off_cand    = cand - r_base;
    assign cand_in     = (cand >= r_base) && (off_cand < POOL_N);
    assign pde_addr    = {off_dir[PW-1:0], r_vp[2*IDX_W-1:IDX_W]};
    assign pte_addr    = {r_toff, r_vp[IDX_W-1:0]};

    always_comb begin
        n_state   = r_state;
        n_clr     = r_clr;
        n_table   = r_table;
        n_toff    = r_toff;
        n_status  = r_status;
        n_old     = r_old;
        n_flush   = r_flush;
        n_done    = r_done;
        n_next    = r_next;
        ram_we    = 1'b0;
        ram_addr  = pde_addr;
        ram_wdata = '0;
        if (r_done && out_free) begin
            n_done = 1'b0;
        end
        case (r_state)
            S_SWEEP: begin
                ram_we   = 1'b1;
                ram_addr = r_clr;
                n_clr    = r_clr + 1'b1;
                if (r_clr == LAST_ADDR) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (s_accept) begin
                    n_state  = S_CHK;
                    n_status = ST_DONE;
                    n_old    = '0;
                    n_flush  = 1'b0;
                end
            end
            S_CHK: begin
                // Directory entry read is issued here; data arrives in S_PDE.
                if (!dir_in) begin
                    n_status = ST_OUT_POOL;
                    n_done   = 1'b1;
                    n_state  = S_IDLE;
                end else begin
                    n_state = S_PDE;
                end
            end
            S_PDE: begin
                n_table = cand;
                n_toff  = off_cand[PW-1:0];
                n_clr   = '0;
                if (r_op == OP_MAP) begin
                    if (pde_present) begin
                        if (!cand_in) begin
                            n_status = ST_OUT_POOL;
                            n_done   = 1'b1;
                            n_state  = S_IDLE;
                        end else begin
                            n_state = S_WR_PTE;
                        end
                    end else if (r_next >= r_limit) begin
                        n_status = ST_NO_TABLE;
                        n_done   = 1'b1;
                        n_state  = S_IDLE;
                    end else if (!cand_in) begin
                        n_status = ST_OUT_POOL;
                        n_done   = 1'b1;
                        n_state  = S_IDLE;
                    end else begin
                        n_next  = r_next + 1'b1;
                        n_state = S_TCLR;
                    end
                end else begin
                    if (!pde_present) begin
                        n_status = ST_NOT_MAPPED;
                        n_done   = 1'b1;
                        n_state  = S_IDLE;
                    end else if (!cand_in) begin
                        n_status = ST_OUT_POOL;
                        n_done   = 1'b1;
                        n_state  = S_IDLE;
                    end else begin
                        ram_addr = {off_cand[PW-1:0], r_vp[IDX_W-1:0]};
                        n_state  = S_PTE;
                    end
                end
            end
            S_TCLR: begin
                ram_we   = 1'b1;
                ram_addr = {r_toff, r_clr[IDX_W-1:0]};
                n_clr    = r_clr + 1'b1;
                if (r_clr[IDX_W-1:0] == {IDX_W{1'b1}}) begin
                    n_state = S_WR_PDE;
                end
            end
            S_WR_PDE: begin
                ram_we    = 1'b1;
                ram_addr  = pde_addr;
                ram_wdata = {r_table, r_attrs | ATTR_W'(1)};
                n_state   = S_WR_PTE;
            end
            S_WR_PTE: begin
                ram_we    = 1'b1;
                ram_addr  = pte_addr;
                ram_wdata = {r_phys, r_attrs | ATTR_W'(1)};
                n_flush   = 1'b1;
                n_done    = 1'b1;
                n_state   = S_IDLE;
            end
            S_PTE: begin
                ram_addr = pte_addr;
                if (!ram_rdata[0]) begin
                    n_status = ST_NOT_MAPPED;
                end else begin
                    ram_we  = 1'b1;
                    n_old   = ram_rdata[ENTRY_W-1:ATTR_W];
                    n_flush = 1'b1;
                end
                n_done  = 1'b1;
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
        // Writing the start frame also reloads the allocator.
        if (cfg_wr && i_cfg_index == CFG_ALLOC_START) begin
            n_next = i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_SWEEP;
            r_clr   <= '0;
            r_done  <= 1'b0;
            r_next  <= RST_ALLOC_START;
            r_limit <= RST_ALLOC_LIMIT;
            r_base  <= RST_POOL_BASE;
            r_m_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_clr   <= n_clr;
            r_done  <= n_done;
            r_next  <= n_next;
            if (cfg_wr) begin
                case (i_cfg_index)
                    CFG_ALLOC_LIMIT: r_limit <= i_cfg_data;
                    CFG_POOL_BASE:   r_base  <= i_cfg_data;
                    default: ;
                endcase
            end
            if (r_done && out_free) begin
                r_m_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_m_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_accept) begin
            r_op    <= t_opcode'(i_s_tuser);
            r_dir   <= i_s_tdata[FRAME_W-1:0];
            r_vp    <= i_s_tdata[2*FRAME_W-1:FRAME_W];
            r_phys  <= i_s_tdata[3*FRAME_W-1:2*FRAME_W];
            r_attrs <= i_s_tdata[3*FRAME_W+ATTR_W-1:3*FRAME_W];
        end
        r_table  <= n_table;
        r_toff   <= n_toff;
        r_status <= n_status;
        r_old    <= n_old;
        r_flush  <= n_flush;
        if (r_done && out_free) begin
            r_m_status <= r_status;
            r_m_old    <= r_old;
            r_m_flush  <= r_flush;
        end
    end

    assign o_m_tvalid = r_m_valid;
    assign o_m_tdata  = {4'd0, r_m_old};
    assign o_m_tuser  = {r_m_flush, r_m_status};

`ifndef ASSERT_OFF
    a_no_accept_in_sweep: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SWEEP) |-> !o_s_tready)
        else $error("request accepted during reset sweep");

    a_flush_means_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && o_m_tuser[2]) |-> (o_m_tuser[1:0] == ST_DONE))
        else $error("flush raised on a failed request");

    a_old_needs_flush: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && o_m_tdata[19:0] != 20'd0) |-> o_m_tuser[2])
        else $error("old frame reported without a change");

    a_alloc_only_on_new_table: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_rst_n && r_state != S_PDE && !(i_cfg_valid && i_cfg_index == CFG_ALLOC_START))
        |=> $stable(r_next))
        else $error("allocator moved outside a table allocation");

    a_table_clear_in_pool: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_rst_n && r_state == S_PDE && n_state == S_TCLR) |=> (r_state == S_TCLR && r_clr == '0))
        else $error("table clear did not start at entry zero");
`endif

endmodule
